// ===== design/rps_pkg.sv =====
// Shared types and constants of the RGB parade scope.
package rps_pkg;

	localparam int LEVEL_W = 8;
	localparam int COUNT_W = 16;
	localparam int GAIN_W  = 9;
	localparam int PROD_W  = COUNT_W + GAIN_W;
	localparam int COMPS   = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = 16'hFFFF;
	localparam logic [LEVEL_W-1:0] INTENSITY_MAX = 8'd255;
	localparam logic [GAIN_W-1:0]  GAIN_RESET    = 9'd100;

	typedef enum logic [1:0] {
		MODE_ACC   = 2'd0,
		MODE_READ  = 2'd1,
		MODE_CLEAR = 2'd2
	} mode_t;

	typedef enum logic {
		CFG_ENABLE = 1'b0,
		CFG_GAIN   = 1'b1
	} cfg_index_t;

endpackage

// ===== design/rgb_parade_scope_core.sv =====
// RGB parade scope: per-column level counters per component, kept in three memories.
//
// Input stream (s_*): tuser carries the mode, tdata the pixel or display point.
// Accumulate bumps three saturating 16-bit counters at one column, one per
// component. Read returns min(255, gain * count) for one display point with the
// panel as tuser on the output stream (m_*). Clear zeroes every counter.
// Configuration (cfg_*): index 0 enable, index 1 gain; always ready.
//
// Throughput: one item per cycle while no clear sweep runs and no read stalls. Counters live in three single-port-write
// memories with a registered read; the read-modify-write of an accumulate
// spans the accept cycle and the next, and the value just written is forwarded
// to the next item so back-to-back pixels on one counter add up correctly.
// Read path: an accepted read is registered in stage 1, then in the output register.
// Clear and reset: a sweep writes zeros over all COLUMNS*256 entries, one entry of
// all three memories per cycle; s_tready stays low meanwhile.
// Stall: a read result waits in the output register; while it waits and a
// further read result is ready behind it, s_tready drops until m_tready rises.
module rgb_parade_scope_core #(
	parameter int COLUMNS = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [8:0] column, [16:9] comp_first, [24:17] comp_second, [32:25] comp_third,
	// [43:33] scope_x, [51:44] scope_row, [55:52] zero
	input  logic [55:0] s_tdata,
	// [1:0] mode
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] intensity
	output logic [7:0]  m_tdata,
	// [1:0] slot
	output logic [1:0]  m_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int AW    = CW + rps_pkg::LEVEL_W;
	localparam int DEPTH = COLUMNS * 256;
	localparam int NC    = rps_pkg::COMPS;
	localparam int CNT_W = rps_pkg::COUNT_W;

	localparam logic [15:0] COL1 = 16'(COLUMNS);
	localparam logic [15:0] COL2 = 16'(2 * COLUMNS);
	localparam logic [15:0] COL3 = 16'(3 * COLUMNS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

	// configuration
	logic                         enable_q;
	logic [rps_pkg::GAIN_W-1:0]   gain_q;

	// input decode
	logic                         accept;
	rps_pkg::mode_t               mode;
	logic [15:0]                  col_w;
	logic [15:0]                  x_w;
	logic [15:0]                  c_w;
	logic                         col_ok;
	logic                         x_ok;
	logic [1:0]                   panel;
	logic [rps_pkg::LEVEL_W-1:0]  comp [NC];
	logic [rps_pkg::LEVEL_W-1:0]  rd_level;
	logic [AW-1:0]                rd_addr [NC];

	// stage 1
	logic                         acc_s1;
	logic                         rd_s1;
	logic                         x_ok_s1;
	logic [1:0]                   panel_s1;
	logic [AW-1:0]                addr_s1 [NC];
	logic [CNT_W-1:0]             rdata_s1 [NC];
	logic [CNT_W-1:0]             cur [NC];
	logic [CNT_W-1:0]             inc [NC];
	logic                         s1_stall;

	// last write, for forwarding
	logic                         wr_vld_q;
	logic [AW-1:0]                wr_addr_q [NC];
	logic [CNT_W-1:0]             wr_data_q [NC];

	// clear sweep
	logic                         clr_active_q;
	logic [AW-1:0]                clr_cnt_q;

	// read result
	logic [CNT_W-1:0]             sel_count;
	logic [rps_pkg::PROD_W-1:0]   prod;
	logic [7:0]                   intensity;
	logic                         m_valid_q;
	logic [7:0]                   m_data_q;
	logic [1:0]                   m_slot_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			gain_q   <= rps_pkg::GAIN_RESET;
		end else if (cfg_valid) begin
			case (rps_pkg::cfg_index_t'(cfg_index))
				rps_pkg::CFG_ENABLE: enable_q <= cfg_data[0];
				rps_pkg::CFG_GAIN:   gain_q   <= cfg_data;
				default:             ;
			endcase
		end
	end

	assign s1_stall = rd_s1 && m_valid_q && !m_tready;
	assign s_tready = !clr_active_q && !s1_stall;
	assign accept   = s_tvalid && s_tready;
	assign mode     = rps_pkg::mode_t'(s_tuser);

	always_comb begin
		col_w    = 16'(s_tdata[8:0]);
		x_w      = 16'(s_tdata[43:33]);
		comp[0]  = s_tdata[16:9];
		comp[1]  = s_tdata[24:17];
		comp[2]  = s_tdata[32:25];
		rd_level = ~s_tdata[51:44];
		col_ok   = col_w < COL1;
		x_ok     = x_w < COL3;
		// panel counts down from the left edge of the display
		if (x_w >= COL2) begin
			panel = 2'd0;
			c_w   = x_w - COL2;
		end else if (x_w >= COL1) begin
			panel = 2'd1;
			c_w   = x_w - COL1;
		end else begin
			panel = 2'd2;
			c_w   = x_w;
		end
		for (int k = 0; k < NC; k++) begin
			if (mode == rps_pkg::MODE_READ) begin
				rd_addr[k] = {c_w[CW-1:0], rd_level};
			end else begin
				rd_addr[k] = {col_w[CW-1:0], comp[k]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_s1 <= 1'b0;
			rd_s1  <= 1'b0;
		end else if (s_tready) begin
			acc_s1 <= accept && enable_q && (mode == rps_pkg::MODE_ACC) && col_ok;
			rd_s1  <= accept && enable_q && (mode == rps_pkg::MODE_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_ok_s1  <= x_ok;
			panel_s1 <= panel;
			for (int k = 0; k < NC; k++) begin
				addr_s1[k] <= rd_addr[k];
			end
		end
	end

	// forward the previous write: the memory read issued in the same cycle saw old data
	always_comb begin
		for (int k = 0; k < NC; k++) begin
			if (wr_vld_q && (wr_addr_q[k] == addr_s1[k])) begin
				cur[k] = wr_data_q[k];
			end else begin
				cur[k] = rdata_s1[k];
			end
			inc[k] = (cur[k] == rps_pkg::COUNT_MAX) ? cur[k] : cur[k] + 1'b1;
		end
	end

	for (genvar k = 0; k < NC; k++) begin : g_lane
		logic [CNT_W-1:0] mem [DEPTH];

		always_ff @(posedge clk) begin
			if (clr_active_q) begin
				mem[clr_cnt_q] <= '0;
			end else if (acc_s1) begin
				mem[addr_s1[k]] <= inc[k];
			end
			if (accept) begin
				rdata_s1[k] <= mem[rd_addr[k]];
			end
		end
	end

	// hold the forwarding entry while a read waits in stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_vld_q <= 1'b0;
		end else if (clr_active_q) begin
			wr_vld_q <= 1'b0;
		end else if (s_tready) begin
			wr_vld_q <= acc_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_s1) begin
			for (int k = 0; k < NC; k++) begin
				wr_addr_q[k] <= addr_s1[k];
				wr_data_q[k] <= inc[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			if (clr_cnt_q == LAST_ADDR) begin
				clr_active_q <= 1'b0;
				clr_cnt_q    <= '0;
			end else begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end else if (accept && enable_q && (mode == rps_pkg::MODE_CLEAR)) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end
	end

	always_comb begin
		case (panel_s1)
			2'd0:    sel_count = cur[0];
			2'd1:    sel_count = cur[1];
			2'd2:    sel_count = cur[2];
			default: sel_count = '0;
		endcase
		prod = rps_pkg::PROD_W'(gain_q) * rps_pkg::PROD_W'(sel_count);
		if (prod > rps_pkg::PROD_W'(rps_pkg::INTENSITY_MAX)) begin
			intensity = rps_pkg::INTENSITY_MAX;
		end else begin
			intensity = prod[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (rd_s1 && (!m_valid_q || m_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s1 && (!m_valid_q || m_tready)) begin
			m_data_q <= x_ok_s1 ? intensity : 8'd0;
			m_slot_q <= x_ok_s1 ? panel_s1 : 2'd0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_slot_q;

endmodule

// ===== test/tb_top.sv =====
// Testbench of the RGB parade scope: directed table and random phases.
module tb_top;

	localparam int COLUMNS = 512;
	localparam int WATCHDOG_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES = 300;
	localparam int KEEP = -1;
	localparam int ENABLE_ROW = 4;
	localparam int PLAN_ROWS = 24;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [3:0]  pad;
		logic [7:0]  scope_row;
		logic [10:0] scope_x;
		logic [7:0]  comp_third;
		logic [7:0]  comp_second;
		logic [7:0]  comp_first;
		logic [8:0]  column;
	} scope_req_t;

	typedef struct {
		logic [7:0] intensity;
		logic [1:0] slot;
	} readout_t;

	typedef struct {
		logic [1:0]  mode;
		int unsigned col, c0, c1, c2, x, row;
		int          gain;
		bit          typed;
		int unsigned want_i, want_s;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [8:0]  cfg_data;

	// Predictor state: counters absent from the map are zero.
	logic [15:0]     tally [int unsigned];
	logic            en_q;
	logic [8:0]      gain_q;
	readout_t        readout_q [$];
	int              errors;
	bit              steady;
	bit              hold_req;
	logic [8:0]      col_pool [6];
	logic [7:0]      lvl_pool [4];

	plan_row_t plan [PLAN_ROWS] = '{
		'{rps_pkg::MODE_ACC,   3,   9,   9,   9,   0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1027, 246, KEEP, 0, 0,   0},
		'{rps_pkg::MODE_CLEAR, 0,   0,   0,   0,   0,    0,   KEEP, 0, 0,   0},
		'{MODE_UNUSED,         511, 255, 255, 255, 2047, 255, KEEP, 0, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1027, 246, KEEP, 1, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   0,    0,   KEEP, 1, 0,   2},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1536, 0,   KEEP, 1, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   2047, 255, KEEP, 1, 0,   0},
		'{rps_pkg::MODE_ACC,   0,   0,   255, 128, 0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1024, 255, KEEP, 1, 100, 0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   512,  0,   KEEP, 1, 100, 1},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   0,    127, KEEP, 1, 100, 2},
		'{rps_pkg::MODE_ACC,   511, 255, 0,   255, 0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_ACC,   511, 255, 0,   255, 0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_ACC,   511, 255, 0,   255, 0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1535, 0,   KEEP, 1, 255, 0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1023, 255, 1,    0, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   511,  0,   511,  1, 255, 2},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1024, 255, 0,    1, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1023, 255, 500,  0, 0,   0},
		'{rps_pkg::MODE_ACC,   256, 1,   2,   4,   0,    0,   KEEP, 0, 0,   0},
		'{MODE_UNUSED,         0,   0,   0,   0,   0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_CLEAR, 0,   0,   0,   0,   0,    0,   KEEP, 0, 0,   0},
		'{rps_pkg::MODE_READ,  0,   0,   0,   0,   1535, 0,   KEEP, 1, 0,   0}
	};

	rgb_parade_scope_core #(
		.COLUMNS(COLUMNS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40)
			$display("mismatch: %s", what);
	endtask

	function automatic int unsigned tally_key(input int unsigned comp, input int unsigned col,
			input int unsigned lvl);
		return (comp * COLUMNS + col) * 256 + lvl;
	endfunction

	function automatic void bump_count(input int unsigned key);
		if (!tally.exists(key))
			tally[key] = 16'd1;
		else if (tally[key] != rps_pkg::COUNT_MAX)
			tally[key] = tally[key] + 16'd1;
	endfunction

	// Update the counters for one accepted transaction; return 1 when a readout follows.
	function automatic bit scope_step(input logic [1:0] mode, input scope_req_t r,
			output readout_t res);
		int unsigned panel, col, lvl, key, prod, cnt;
		res.intensity = '0;
		res.slot = '0;
		if (!en_q)
			return 1'b0;
		if (mode == rps_pkg::MODE_ACC) begin
			if (r.column < COLUMNS) begin
				bump_count(tally_key(0, r.column, r.comp_first));
				bump_count(tally_key(1, r.column, r.comp_second));
				bump_count(tally_key(2, r.column, r.comp_third));
			end
			return 1'b0;
		end
		if (mode == rps_pkg::MODE_READ) begin
			if (r.scope_x < 3 * COLUMNS) begin
				panel = 2 - r.scope_x / COLUMNS;
				col = r.scope_x % COLUMNS;
				lvl = 255 - r.scope_row;
				key = tally_key(panel, col, lvl);
				cnt = tally.exists(key) ? tally[key] : 0;
				prod = gain_q * cnt;
				res.intensity = (prod > 255) ? rps_pkg::INTENSITY_MAX : 8'(prod);
				res.slot = 2'(panel);
			end
			return 1'b1;
		end
		if (mode == rps_pkg::MODE_CLEAR)
			tally.delete();
		return 1'b0;
	endfunction

	task automatic send_item(input logic [1:0] mode, input scope_req_t r, input bit typed,
			input readout_t want);
		readout_t res;
		while (!steady && $urandom_range(99) < 11) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= r;
		s_tuser <= mode;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (scope_step(mode, r, res)) begin
			if (typed)
				readout_q.push_back(want);
			else
				readout_q.push_back(res);
		end
	endtask

	// Drain outstanding readouts, then give the block time to finish silent work.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input rps_pkg::cfg_index_t idx, input logic [8:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == rps_pkg::CFG_ENABLE)
			en_q = val[0];
		else
			gain_q = val;
		@(posedge clk);
	endtask

	task automatic random_item(input bit force_read);
		scope_req_t  r;
		logic [1:0]  mode;
		int unsigned pick, panel;
		readout_t    none;
		none = '{default: '0};
		r = scope_req_t'(56'({$urandom, $urandom}));
		r.pad = '0;
		pick = $urandom_range(99);
		if (force_read || pick < 42)
			mode = rps_pkg::MODE_READ;
		else if (pick < 95)
			mode = rps_pkg::MODE_ACC;
		else
			mode = MODE_UNUSED;
		// Aim most pixels and reads at a few columns and levels so counts build up.
		if (mode == rps_pkg::MODE_ACC && $urandom_range(9) < 8) begin
			r.column = col_pool[$urandom_range(5)];
			if ($urandom_range(4) != 0) r.comp_first = lvl_pool[$urandom_range(3)];
			if ($urandom_range(4) != 0) r.comp_second = lvl_pool[$urandom_range(3)];
			if ($urandom_range(4) != 0) r.comp_third = lvl_pool[$urandom_range(3)];
		end
		if (mode == rps_pkg::MODE_READ && $urandom_range(9) < 7) begin
			panel = $urandom_range(2);
			r.scope_x = 11'((2 - panel) * COLUMNS + col_pool[$urandom_range(5)]);
			r.scope_row = 8'(255 - lvl_pool[$urandom_range(3)]);
		end
		send_item(mode, r, 1'b0, none);
	endtask

	task automatic run_phase(input int items, input int clear_at);
		scope_req_t r;
		readout_t   none;
		none = '{default: '0};
		foreach (col_pool[i]) col_pool[i] = 9'($urandom_range(511));
		foreach (lvl_pool[i]) lvl_pool[i] = 8'($urandom_range(255));
		for (int i = 0; i < items; i++) begin
			if (i == clear_at) begin
				r = scope_req_t'(56'({$urandom, $urandom}));
				r.pad = '0;
				send_item(rps_pkg::MODE_CLEAR, r, 1'b0, none);
			end
			random_item(i == items - 1);
		end
		settle();
	endtask

	// Receiver: random backpressure, long hold on request, result checking.
	initial begin
		readout_t want;
		int       hold_left;
		hold_left = 0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (readout_q.size() == 0) begin
					report_mismatch($sformatf("unexpected readout %0d/%0d", m_tdata, m_tuser));
				end else begin
					want = readout_q.pop_front();
					if (m_tdata !== want.intensity)
						report_mismatch($sformatf("intensity %0d, want %0d",
							m_tdata, want.intensity));
					if (m_tuser !== want.slot)
						report_mismatch($sformatf("slot %0d, want %0d", m_tuser, want.slot));
				end
			end
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady || ($urandom_range(99) >= 11);
			end
		end
	end

	// Watchdog: a clear sweep, as after reset, is the longest silent stretch.
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	initial begin
		scope_req_t r;
		readout_t   want;
		errors = 0;
		steady = 1'b0;
		hold_req = 1'b0;
		en_q = 1'b0;
		gain_q = rps_pkg::GAIN_RESET;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (i == ENABLE_ROW) begin
				settle();
				write_reg(rps_pkg::CFG_ENABLE, 9'd1);
			end
			if (plan[i].gain != KEEP) begin
				settle();
				write_reg(rps_pkg::CFG_GAIN, 9'(plan[i].gain));
			end
			r = '0;
			r.column = 9'(plan[i].col);
			r.comp_first = 8'(plan[i].c0);
			r.comp_second = 8'(plan[i].c1);
			r.comp_third = 8'(plan[i].c2);
			r.scope_x = 11'(plan[i].x);
			r.scope_row = 8'(plan[i].row);
			want.intensity = 8'(plan[i].want_i);
			want.slot = 2'(plan[i].want_s);
			send_item(plan[i].mode, r, plan[i].typed, want);
		end
		settle();

		// Random phases across the gain extremes, a disabled stretch, and one clear.
		write_reg(rps_pkg::CFG_GAIN, 9'd1);
		steady = 1'b1;
		run_phase(200, KEEP);
		steady = 1'b0;
		write_reg(rps_pkg::CFG_GAIN, 9'd500);
		hold_req = 1'b1;
		run_phase(200, KEEP);
		write_reg(rps_pkg::CFG_GAIN, 9'd0);
		run_phase(200, 100);
		write_reg(rps_pkg::CFG_ENABLE, 9'd0);
		run_phase(30, KEEP);
		write_reg(rps_pkg::CFG_ENABLE, 9'd1);
		write_reg(rps_pkg::CFG_GAIN, 9'($urandom_range(499, 2)));
		run_phase(200, KEEP);
		write_reg(rps_pkg::CFG_GAIN, 9'd511);
		run_phase(200, KEEP);

		if (errors == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
